// ===== src/truetype_directory_checker_assert.svh =====
// ----------------------------------------------------------------------------
// TrueType directory checker assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRUETYPE_DIRECTORY_CHECKER_ASSERT_SVH
`define TRUETYPE_DIRECTORY_CHECKER_ASSERT_SVH

`ifndef SYNTH
// Check a condition at every clock edge outside reset
`define TDC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("tdc assertion failed");
// Check that an antecedent implies a consequent in the next cycle
`define TDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tdc assertion failed");
`else
`define TDC_ASSERT(lbl, cond)
`define TDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// TrueType directory checker package
// Shared constants, event and status codes, and the tag display function.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int unsigned POS_W         = 21;
    localparam int unsigned FIFO_DEPTH    = 4;

    localparam logic [31:0] HDR_BYTES      = 32'd12;
    localparam logic [31:0] TAG_TRUETYPE   = 32'h0001_0000;
    localparam logic [31:0] TAG_APPLE      = 32'h7472_7565;
    localparam logic [31:0] TAG_COLLECTION = 32'h7474_6366;
    localparam logic [31:0] TAG_CFF        = 32'h4F54_544F;
    localparam logic [7:0]  PRINT_LOW      = 8'h20;
    localparam logic [7:0]  PRINT_END      = 8'h7F;
    localparam logic [7:0]  CHAR_QUERY     = 8'h3F;

    // Low nibble of the byte position at the last byte of each record field
    localparam logic [3:0]  NIB_TAG_END    = 4'd15;
    localparam logic [3:0]  NIB_OFF_END    = 4'd7;
    localparam logic [3:0]  NIB_LEN_END    = 4'd11;
    localparam logic [POS_W-1:0] POS_FLAVOUR_END = POS_W'(3);
    localparam logic [POS_W-1:0] POS_COUNT_END   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HDR_END     = POS_W'(12);

    // Kind of work the back end has to do for one byte
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_FLAVOUR = 3'd2,
        EV_COUNT   = 3'd3,
        EV_TAG     = 3'd4,
        EV_OFFSET  = 3'd5,
        EV_LENGTH  = 3'd6
    } t_ev_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_COLLECTION  = 3'd2,
        ST_CFF         = 3'd3,
        ST_BAD_FLAVOUR = 3'd4,
        ST_NO_TABLES   = 3'd5,
        ST_DIR_OVERRUN = 3'd6,
        ST_TBL_OVERRUN = 3'd7
    } t_status;

    typedef struct packed {
        t_ev_kind    kind;
        logic [31:0] field;
        logic [31:0] size;
    } t_event;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Replace non-printable tag bytes with a question mark
    function automatic logic [31:0] shown_tag(input logic [31:0] tag);
        logic [31:0] res;
        logic [7:0]  b;
        res = '0;
        for (int i = 0; i < 4; i++) begin
            b = tag[8*i +: 8];
            if (b < PRINT_LOW || b >= PRINT_END) begin
                b = CHAR_QUERY;
            end
            res[8*i +: 8] = b;
        end
        return res;
    endfunction

endpackage

// ===== src/truetype_directory_checker.sv =====
// Path: a deciding byte is registered in the event queue and then in the output register
// before its verdict shows on m_axis; queued events ahead of it hold it back.
// Throughput: one byte per cycle; a verdict held on m_axis stops the back end, and
// s_axis stalls once the event queue is full.
// Reset (synchronous, i_rst_n low): queue empties, no verdict pending, bytes are ignored
// until a byte arrives with start_font set.
// ----------------------------------------------------------------------------
// TrueType directory checker
// Streams font bytes, validates the offset table and directory, emits a verdict.
// ----------------------------------------------------------------------------
`include "truetype_directory_checker_assert.svh"

module truetype_directory_checker
    import tdc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [7:0] data_byte, [39:8] font_size
    input  logic        s_axis_tuser,  // [0] start_font
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // [2:0] status, [18:3] bad_table_index,
                                       // [50:19] shown_tag, [55:51] zero
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic          w_fire;
    logic          w_push;
    t_event        w_in_event;
    t_event        w_q_event;
    t_fifo_stat    w_q_stat;
    logic [CW-1:0] w_q_count;
    logic          w_pop;
    logic [2:0]    w_status;
    logic [15:0]   w_index;
    logic [31:0]   w_tag;

    assign s_axis_tready = !w_q_stat.full;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    tdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_data_byte  (s_axis_tdata[7:0]),
        .i_font_size  (s_axis_tdata[39:8]),
        .i_start_font (s_axis_tuser),
        .o_push       (w_push),
        .o_event      (w_in_event)
    );

    tdc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_event (w_in_event),
        .i_pop   (w_pop),
        .o_event (w_q_event),
        .o_stat  (w_q_stat),
        .o_count (w_q_count)
    );

    tdc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_event           (w_q_event),
        .i_avail           (!w_q_stat.empty),
        .o_pop             (w_pop),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_status          (w_status),
        .o_bad_table_index (w_index),
        .o_shown_tag       (w_tag)
    );

    assign m_axis_tdata = {5'd0, w_tag, w_index, w_status};

    // Queue fill never exceeds its depth
    `TDC_ASSERT(a_queue_bound, w_q_count <= CW'(QUEUE_DEPTH))
    // Failing index is only reported with a table overrun
    `TDC_ASSERT(a_index_only_overrun,
        !m_axis_tvalid || w_status == ST_TBL_OVERRUN || w_index == 16'd0)
    // Tag is blank for ok, short, no tables and directory overrun
    `TDC_ASSERT(a_tag_blank,
        !m_axis_tvalid || w_tag == 32'd0 || w_status == ST_COLLECTION ||
        w_status == ST_CFF || w_status == ST_BAD_FLAVOUR || w_status == ST_TBL_OVERRUN)
    // An empty queue fills by at most one entry per cycle
    `TDC_ASSERT_NEXT(a_queue_step, w_q_stat.empty, w_q_count <= CW'(1))

endmodule

// ===== src/tdc_front.sv =====
// ----------------------------------------------------------------------------
// TrueType directory checker front end
// Tracks byte position, assembles big-endian fields, classifies each byte.
// ----------------------------------------------------------------------------
module tdc_front
    import tdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_font_size,
    input  logic        i_start_font,
    output logic        o_push,
    output t_event      o_event
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_shift, n_shift;
    logic [POS_W-1:0] w_p;
    t_ev_kind         w_kind;

    // Assemble field and pick the position of this byte
    always_comb begin
        w_p     = i_start_font ? '0 : r_pos;
        n_pos   = w_p + POS_W'(1);
        n_shift = i_start_font ? {24'd0, i_data_byte} : {r_shift[23:0], i_data_byte};
    end

    // Classify the byte by its place in the header or directory
    always_comb begin
        w_kind = EV_NONE;
        if (i_start_font) begin
            w_kind = EV_START;
        end else if (w_p == POS_FLAVOUR_END) begin
            w_kind = EV_FLAVOUR;
        end else if (w_p == POS_COUNT_END) begin
            w_kind = EV_COUNT;
        end else if (w_p >= POS_HDR_END) begin
            unique case (w_p[3:0])
                NIB_TAG_END: w_kind = EV_TAG;
                NIB_OFF_END: w_kind = EV_OFFSET;
                NIB_LEN_END: w_kind = EV_LENGTH;
                default:     w_kind = EV_NONE;
            endcase
        end
    end

    assign o_push        = i_fire && (w_kind != EV_NONE);
    assign o_event.kind  = w_kind;
    assign o_event.field = n_shift;
    assign o_event.size  = i_font_size;

    // Advance position on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_shift <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_shift <= n_shift;
        end
    end

endmodule

// ===== src/tdc_fifo.sv =====
// ----------------------------------------------------------------------------
// TrueType directory checker event queue
// Short register queue between front and back end.
// ----------------------------------------------------------------------------
module tdc_fifo
    import tdc_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_event      i_event,
    input  logic        i_pop,
    output t_event      o_event,
    output t_fifo_stat  o_stat,
    output logic [CW-1:0] o_count
);

    t_event        r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_count      = r_cnt;
    assign o_event      = r_mem[r_rd];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    // Store incoming events
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== src/tdc_back.sv =====
// ----------------------------------------------------------------------------
// TrueType directory checker back end
// Runs the header and record checks and holds the verdict register.
// ----------------------------------------------------------------------------
module tdc_back
    import tdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_event      i_event,
    input  logic        i_avail,
    output logic        o_pop,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_bad_table_index,
    output logic [31:0] o_shown_tag
);

    logic        r_verdict, n_verdict;
    logic [15:0] r_count, n_count;
    logic [15:0] r_index, n_index;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_offset, n_offset;
    logic        r_out_valid;
    t_status     r_status, w_status;
    logic [15:0] r_out_index, w_index;
    logic [31:0] r_out_tag, w_tag;
    logic        w_emit;
    logic [20:0] w_dir_end;
    logic [15:0] w_next_index;
    logic        w_tbl_bad;

    assign o_pop        = i_avail && (!r_out_valid || i_out_ready);
    assign w_dir_end    = 21'd12 + {1'b0, i_event.field[15:0], 4'd0};
    assign w_next_index = r_index + 16'd1;
    assign w_tbl_bad    = (r_offset > i_event.size) ||
                          (i_event.field > (i_event.size - r_offset));

    // Evaluate the popped event
    always_comb begin
        n_verdict = r_verdict;
        n_count   = r_count;
        n_index   = r_index;
        n_tag     = r_tag;
        n_offset  = r_offset;
        w_emit    = 1'b0;
        w_status  = ST_OK;
        w_index   = '0;
        w_tag     = '0;
        if (o_pop) begin
            unique case (i_event.kind)
                EV_START: begin
                    n_verdict = 1'b0;
                    n_count   = '0;
                    n_index   = '0;
                    n_tag     = '0;
                    n_offset  = '0;
                    if (i_event.size < HDR_BYTES) begin
                        w_emit   = 1'b1;
                        w_status = ST_SHORT;
                    end
                end
                EV_FLAVOUR: begin
                    if (!r_verdict) begin
                        w_tag = shown_tag(i_event.field);
                        if (i_event.field == TAG_COLLECTION) begin
                            w_emit   = 1'b1;
                            w_status = ST_COLLECTION;
                        end else if (i_event.field == TAG_CFF) begin
                            w_emit   = 1'b1;
                            w_status = ST_CFF;
                        end else if (i_event.field != TAG_TRUETYPE &&
                                     i_event.field != TAG_APPLE) begin
                            w_emit   = 1'b1;
                            w_status = ST_BAD_FLAVOUR;
                        end
                    end
                end
                EV_COUNT: begin
                    if (!r_verdict) begin
                        n_count = i_event.field[15:0];
                        if (i_event.field[15:0] == 16'd0) begin
                            w_emit   = 1'b1;
                            w_status = ST_NO_TABLES;
                        end else if ({11'd0, w_dir_end} > i_event.size) begin
                            w_emit   = 1'b1;
                            w_status = ST_DIR_OVERRUN;
                        end
                    end
                end
                EV_TAG: begin
                    if (!r_verdict) begin
                        n_tag = i_event.field;
                    end
                end
                EV_OFFSET: begin
                    if (!r_verdict) begin
                        n_offset = i_event.field;
                    end
                end
                EV_LENGTH: begin
                    if (!r_verdict) begin
                        if (w_tbl_bad) begin
                            w_emit   = 1'b1;
                            w_status = ST_TBL_OVERRUN;
                            w_index  = r_index;
                            w_tag    = shown_tag(r_tag);
                        end else begin
                            n_index = w_next_index;
                            if (w_next_index >= r_count) begin
                                w_emit   = 1'b1;
                                w_status = ST_OK;
                            end
                        end
                    end
                end
                EV_NONE: ;
                default: ;
            endcase
            if (w_emit) begin
                n_verdict = 1'b1;
            end
        end
        if (!w_emit) begin
            w_tag = '0;
        end
    end

    // Hold checker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict <= 1'b1;
            r_count   <= '0;
            r_index   <= '0;
            r_tag     <= '0;
            r_offset  <= '0;
        end else begin
            r_verdict <= n_verdict;
            r_count   <= n_count;
            r_index   <= n_index;
            r_tag     <= n_tag;
            r_offset  <= n_offset;
        end
    end

    // Output register: load a verdict, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_status    <= w_status;
            r_out_index <= w_index;
            r_out_tag   <= w_tag;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_bad_table_index = r_out_index;
    assign o_shown_tag       = r_out_tag;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TrueType directory checker testbench
// Feeds font bytes through the slave stream: a short table of hand-checked
// bytes, a few crafted directories, then random fonts (mostly well formed,
// with truncated, misflavoured and oversized ones mixed in). A behavioral
// model of the header and directory checks predicts later verdicts; every
// master stream verdict is compared field by field against its expectation.
// ----------------------------------------------------------------------------
module tb;
    import tdc_pkg::*;

    localparam int unsigned REC_LEN      = 16;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_WAIT   = 20;
    localparam int unsigned ITEM_GOAL    = 1000;
    localparam int unsigned VERDICT_GOAL = 40;
    localparam int unsigned REPORT_MAX   = 10;

    // Byte positions that close a header field or a directory record field
    localparam logic [20:0] FLAVOUR_LAST = 21'd3;
    localparam logic [20:0] COUNT_LAST   = 21'd5;
    localparam logic [3:0]  REC_TAG_LAST = 4'd3;
    localparam logic [3:0]  REC_OFF_LAST = 4'd11;
    localparam logic [3:0]  REC_LEN_LAST = 4'd15;

    typedef struct {
        t_status     status;
        logic [15:0] index;
        logic [31:0] tag;
    } t_verdict;

    typedef struct {
        logic [7:0]  data;
        logic [31:0] size;
        bit          start;
        bit          has_verdict;
        t_verdict    want;
    } t_stim_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [7:0] data_byte, [39:8] font_size
    logic        s_axis_tuser;   // [0] start_font
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [2:0] status, [18:3] bad_table_index,
                                 // [50:19] shown_tag, [55:51] zero

    // Model state of the directory walk
    logic [20:0] ck_pos;
    logic [31:0] ck_shift;
    logic [15:0] ck_count;
    logic [15:0] ck_rec_idx;
    logic [31:0] ck_rec_tag;
    logic [31:0] ck_rec_off;
    bit          ck_done;

    t_verdict    pending_verdicts[$];
    logic [31:0] font_off[$];
    logic [31:0] font_len[$];
    bit          steady_send;
    int unsigned n_items;
    int unsigned n_verdicts;
    int unsigned n_fail;
    int unsigned idle_cycles;

    // Hand-checked bytes: verdicts here follow directly from the header rules
    t_stim_row directed_rows [28] = '{
        // byte before any start is dropped
        '{8'hA5, 32'd100,        1'b0, 1'b0, '{ST_OK, '0, '0}},
        // size below the header length, verdict on the start byte
        '{8'h00, 32'd0,          1'b1, 1'b1, '{ST_SHORT, '0, '0}},
        '{8'hFF, 32'd11,         1'b1, 1'b1, '{ST_SHORT, '0, '0}},
        // collection flavour at the largest size
        '{8'h74, 32'hFFFF_FFFF,  1'b1, 1'b0, '{ST_OK, '0, '0}},
        '{8'h74, 32'hFFFF_FFFF,  1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h63, 32'hFFFF_FFFF,  1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h66, 32'hFFFF_FFFF,  1'b0, 1'b1, '{ST_COLLECTION, '0, 32'h7474_6366}},
        // CFF flavour at exactly the header length
        '{8'h4F, 32'd12,         1'b1, 1'b0, '{ST_OK, '0, '0}},
        '{8'h54, 32'd12,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h54, 32'd12,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h4F, 32'd12,         1'b0, 1'b1, '{ST_CFF, '0, 32'h4F54_544F}},
        // unknown flavour with printable-range edges on both sides
        '{8'h1F, 32'd40,         1'b1, 1'b0, '{ST_OK, '0, '0}},
        '{8'h20, 32'd40,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h7E, 32'd40,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h7F, 32'd40,         1'b0, 1'b1, '{ST_BAD_FLAVOUR, '0, 32'h3F20_7E3F}},
        // TrueType flavour with a zero table count
        '{8'h00, 32'd12,         1'b1, 1'b0, '{ST_OK, '0, '0}},
        '{8'h01, 32'd12,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h00, 32'd12,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h00, 32'd12,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h00, 32'd12,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h00, 32'd12,         1'b0, 1'b1, '{ST_NO_TABLES, '0, '0}},
        // one table needs 28 bytes of directory, size is one short
        '{8'h74, 32'd27,         1'b1, 1'b0, '{ST_OK, '0, '0}},
        '{8'h72, 32'd27,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h75, 32'd27,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h65, 32'd27,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h00, 32'd27,         1'b0, 1'b0, '{ST_OK, '0, '0}},
        '{8'h01, 32'd27,         1'b0, 1'b1, '{ST_DIR_OVERRUN, '0, '0}},
        // byte after a verdict is dropped
        '{8'h5A, 32'd27,         1'b0, 1'b0, '{ST_OK, '0, '0}}
    };

    truetype_directory_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Swap bytes outside the printable range for a question mark
    function automatic logic [31:0] printable_tag(input logic [31:0] tag);
        logic [31:0] res;
        logic [7:0]  ch;
        res = '0;
        for (int s = 24; s >= 0; s -= 8) begin
            ch = tag[s +: 8];
            if (ch < PRINT_LOW || ch >= PRINT_END) begin
                ch = CHAR_QUERY;
            end
            res = {res[23:0], ch};
        end
        return res;
    endfunction

    function automatic logic [31:0] random_tag();
        logic [31:0] t;
        t = '0;
        repeat (4) begin
            if ($urandom_range(0, 99) < 85) begin
                t = {t[23:0], 8'($urandom_range(32'h20, 32'h7E))};
            end else begin
                t = {t[23:0], 8'($urandom)};
            end
        end
        return t;
    endfunction

    // Advance the directory walk by one byte and return the verdict it causes
    task automatic check_font_byte(input logic [7:0] b, input logic [31:0] size,
                                   input bit start, output bit has_v, output t_verdict v);
        logic [20:0] p;
        logic [3:0]  k;
        logic [31:0] dir_end;
        has_v = 1'b0;
        v     = '{ST_OK, '0, '0};
        if (start) begin
            ck_pos     = '0;
            ck_shift   = '0;
            ck_count   = '0;
            ck_rec_idx = '0;
            ck_rec_tag = '0;
            ck_rec_off = '0;
            ck_done    = 1'b0;
            if (size < HDR_BYTES) begin
                has_v = 1'b1;
                v     = '{ST_SHORT, '0, '0};
            end
        end
        if (!ck_done && !has_v) begin
            ck_shift = {ck_shift[23:0], b};
            p        = ck_pos;
            ck_pos   = p + 21'd1;
            k        = p[3:0] - 4'd12;
            if (p == FLAVOUR_LAST) begin
                if (ck_shift == TAG_COLLECTION) begin
                    has_v = 1'b1;
                    v     = '{ST_COLLECTION, '0, printable_tag(ck_shift)};
                end else if (ck_shift == TAG_CFF) begin
                    has_v = 1'b1;
                    v     = '{ST_CFF, '0, printable_tag(ck_shift)};
                end else if (ck_shift != TAG_TRUETYPE && ck_shift != TAG_APPLE) begin
                    has_v = 1'b1;
                    v     = '{ST_BAD_FLAVOUR, '0, printable_tag(ck_shift)};
                end
            end else if (p == COUNT_LAST) begin
                ck_count = ck_shift[15:0];
                dir_end  = HDR_BYTES + REC_LEN * ck_count;
                if (ck_count == 16'd0) begin
                    has_v = 1'b1;
                    v     = '{ST_NO_TABLES, '0, '0};
                end else if (dir_end > size) begin
                    has_v = 1'b1;
                    v     = '{ST_DIR_OVERRUN, '0, '0};
                end
            end else if (p >= HDR_BYTES) begin
                if (k == REC_TAG_LAST) begin
                    ck_rec_tag = ck_shift;
                end else if (k == REC_OFF_LAST) begin
                    ck_rec_off = ck_shift;
                end else if (k == REC_LEN_LAST) begin
                    if (ck_rec_off > size || ck_shift > size - ck_rec_off) begin
                        has_v = 1'b1;
                        v     = '{ST_TBL_OVERRUN, ck_rec_idx, printable_tag(ck_rec_tag)};
                    end else begin
                        ck_rec_idx = ck_rec_idx + 16'd1;
                        if (ck_rec_idx >= ck_count) begin
                            has_v = 1'b1;
                            v     = '{ST_OK, '0, '0};
                        end
                    end
                end
            end
        end
        if (has_v) begin
            ck_done = 1'b1;
        end
    endtask

    // Drive one byte, hold it until the transaction completes, then predict
    task automatic send_byte(input logic [7:0] b, input logic [31:0] size, input bit start,
                             output bit has_v, output t_verdict v);
        int unsigned gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {size, b};
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        check_font_byte(b, size, start, has_v, v);
    endtask

    // Stall the sender until every predicted verdict has been taken
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Build header and records, then stream them, cut after cut_at bytes if nonzero, plus trailing noise
    task automatic stream_font(input logic [31:0] flavour, input logic [31:0] size,
                               input logic [15:0] count_field, input int unsigned nrec,
                               input int unsigned cut_at, input int unsigned trail);
        logic [7:0]   font_bytes[$];
        logic [127:0] rec;
        logic [31:0]  sz;
        logic [7:0]   b;
        int unsigned  body;
        bit           has_v;
        t_verdict     v;
        for (int s = 24; s >= 0; s -= 8) font_bytes.insert(font_bytes.size(), flavour[s +: 8]);
        font_bytes.insert(font_bytes.size(), count_field[15:8]);
        font_bytes.insert(font_bytes.size(), count_field[7:0]);
        repeat (6) font_bytes.insert(font_bytes.size(), 8'($urandom));
        for (int i = 0; i < nrec; i++) begin
            rec = {random_tag(), 32'($urandom),
                   (i < font_off.size()) ? font_off[i] : 32'($urandom),
                   (i < font_len.size()) ? font_len[i] : 32'($urandom)};
            for (int s = 120; s >= 0; s -= 8) font_bytes.insert(font_bytes.size(), rec[s +: 8]);
        end
        body = (cut_at != 0 && cut_at < font_bytes.size()) ? cut_at : font_bytes.size();
        steady_send = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < body + trail; i++) begin
            // now and then move the size mid-font; each check takes the current value
            sz = ($urandom_range(0, 49) == 0) ? 32'($urandom) : size;
            b  = (i < body) ? font_bytes[i] : 8'($urandom);
            send_byte(b, sz, i == 0, has_v, v);
            if (i < body) begin
                n_items++;
            end
            if (has_v) begin
                pending_verdicts.insert(pending_verdicts.size(), v);
                n_verdicts++;
            end
        end
        font_off.delete();
        font_len.delete();
    endtask

    // Mostly well-formed directories with random content, the rest broken headers
    task automatic random_font();
        int unsigned sel;
        int unsigned count;
        int unsigned nrec;
        int unsigned cut_at;
        int unsigned trail;
        logic [31:0] flavour;
        logic [31:0] size;
        logic [31:0] dir_end;
        logic [31:0] off;
        logic [31:0] len;
        sel     = $urandom_range(0, 99);
        count   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        flavour = $urandom_range(0, 1) ? TAG_TRUETYPE : TAG_APPLE;
        dir_end = HDR_BYTES + REC_LEN * count;
        case ($urandom_range(0, 9))
            7, 8: begin
                size = $urandom;
                if (size < dir_end) begin
                    size = dir_end;
                end
            end
            9: begin
                size = '1;
            end
            default: begin
                size = dir_end + $urandom_range(0, 300);
            end
        endcase
        nrec = 0;
        if (sel < 72) begin
            nrec = count;
            for (int i = 0; i < count; i++) begin
                case ($urandom_range(0, 19))
                    0: begin
                        off = size;
                        len = '0;
                    end
                    1: begin
                        off = $urandom_range(0, size);
                        len = size - off;
                    end
                    2: begin
                        off = size + 32'd1;
                        len = '0;
                    end
                    3: begin
                        off = $urandom_range(0, size);
                        len = size - off + 32'd1;
                    end
                    default: begin
                        off = $urandom_range(0, size);
                        len = $urandom_range(0, size - off);
                    end
                endcase
                font_off.insert(font_off.size(), off);
                font_len.insert(font_len.size(), len);
            end
        end else if (sel < 76) begin
            flavour = TAG_COLLECTION;
        end else if (sel < 80) begin
            flavour = TAG_CFF;
        end else if (sel < 87) begin
            flavour = $urandom;
        end else if (sel < 91) begin
            count = 0;
        end else if (sel < 96) begin
            count = $urandom_range(1, 65535);
            size  = $urandom_range(12, HDR_BYTES + REC_LEN * count - 1);
        end else begin
            size = $urandom_range(0, 11);
        end
        cut_at = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 11 + REC_LEN * nrec) : 0;
        trail  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        stream_font(flavour, size, count[15:0], nrec, cut_at, trail);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        n_fail++;
        if (n_fail <= REPORT_MAX) begin
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endtask

    // Compare each verdict transaction with the oldest prediction
    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        t_status  got_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = t_status'(m_axis_tdata[2:0]);
            if (pending_verdicts.size() == 0) begin
                note_mismatch("unpredicted verdict, status", '0, 32'(got_status));
            end else begin
                want = pending_verdicts.pop_front();
                if (got_status != want.status) begin
                    note_mismatch("status", 32'(want.status), 32'(got_status));
                end
                if (m_axis_tdata[18:3] != want.index) begin
                    note_mismatch("bad_table_index", 32'(want.index), 32'(m_axis_tdata[18:3]));
                end
                if (m_axis_tdata[50:19] != want.tag) begin
                    note_mismatch("shown_tag", want.tag, m_axis_tdata[50:19]);
                end
            end
        end
    end

    // End the run if neither stream moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL truetype_directory_checker");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Verdict sink: random stalls with occasional long ready stretches
    initial begin : verdict_sink
        int unsigned hold;
        m_axis_tready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            hold = pick_gap();
            if (hold != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin : byte_source
        bit       has_v;
        t_verdict v;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        steady_send   = 1'b0;
        n_items       = 0;
        n_verdicts    = 0;
        ck_pos        = '0;
        ck_shift      = '0;
        ck_count      = '0;
        ck_rec_idx    = '0;
        ck_rec_tag    = '0;
        ck_rec_off    = '0;
        ck_done       = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the hand-checked rows; the model only keeps its state in step
        foreach (directed_rows[r]) begin
            send_byte(directed_rows[r].data, directed_rows[r].size, directed_rows[r].start,
                      has_v, v);
            if (directed_rows[r].has_verdict) begin
                pending_verdicts.insert(pending_verdicts.size(), directed_rows[r].want);
                n_verdicts++;
            end
        end
        hold_until_drained();

        // last record ends exactly at the size: offset at the end, then full length
        font_off = '{32'd60, 32'd0};
        font_len = '{32'd0, 32'd60};
        stream_font(TAG_TRUETYPE, 32'd60, 16'd2, 2, 0, 3);
        // offset one past the size with zero length on the second record
        font_off = '{32'd28, 32'd61};
        font_len = '{32'd32, 32'd0};
        stream_font(TAG_APPLE, 32'd60, 16'd2, 2, 0, 0);
        // length one past the end on the first record
        font_off = '{32'd0};
        font_len = '{32'd45};
        stream_font(TAG_TRUETYPE, 32'd44, 16'd1, 1, 0, 0);
        // stream stops inside the directory; the next start takes over
        stream_font(TAG_TRUETYPE, 32'd100, 16'd3, 3, 20, 0);
        // offset at the largest size with zero length
        font_off = '{32'hFFFF_FFFF};
        font_len = '{32'd0};
        stream_font(TAG_APPLE, 32'hFFFF_FFFF, 16'd1, 1, 0, 2);

        while (n_items < ITEM_GOAL || n_verdicts < VERDICT_GOAL) begin
            if ($urandom_range(0, 19) == 0) begin
                hold_until_drained();
            end
            random_font();
        end

        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS truetype_directory_checker");
        end else begin
            $display("FAIL truetype_directory_checker");
        end
        $finish;
    end

endmodule
